// ----- rtl/core/ufwpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufwpc_pkg: shared types and constants for the disjoint-set engine
// Field widths, request codes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ufwpc_pkg;

  // Fixed field widths
  localparam int ELEM_W      = 10;
  localparam int SIZE_W      = 11;
  localparam int SET_COUNT_W = 11;
  localparam int MAX_DEPTH   = 1024;

  // Request codes
  typedef enum logic {
    REQ_FIND  = 1'b0,
    REQ_UNION = 1'b1
  } req_type_e;

  // Controller to datapath
  typedef struct packed {
    logic clr;             // write reset values at the clear index
    logic ld_req;          // capture a new request
    logic sel;             // 0: work on elem_p / root_p, 1: elem_q / root_q
    logic walk_start;      // cur <= elem, read parent[elem]
    logic root_from_elem;  // out-of-range element is its own root
    logic walk_next;       // cur <= parent, read parent[parent]
    logic root_from_cur;   // root found: root <= cur, cur <= elem
    logic comp_read;       // read parent[cur]
    logic comp_write;      // parent[cur] <= root, cur <= old parent
    logic size_rd_a;       // read size[root_p]
    logic size_rd_b;       // read size[root_q], keep size[root_p]
    logic link;            // hang smaller root under larger one
    logic ld_out;          // load the result register
  } ufwpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic elem_in_range;
    logic rd_is_self;
    logic cur_at_root;
    logic rd_at_root;
    logic is_union;
    logic can_merge;
  } ufwpc_status_t;

endpackage

// ----- rtl/core/ufwpc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufwpc_req_if: request channel
// Valid/ready channel carrying one find or union request per transaction.
// ----------------------------------------------------------------------------
interface ufwpc_req_if
  import ufwpc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ELEM_W-1:0] elem_p;
  logic [ELEM_W-1:0] elem_q;

  modport source (output valid, req_type, elem_p, elem_q, input ready);
  modport sink   (input valid, req_type, elem_p, elem_q, output ready);
endinterface

// ----- rtl/core/ufwpc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufwpc_rsp_if: result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface ufwpc_rsp_if
  import ufwpc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [ELEM_W-1:0]      root_p;
  logic [ELEM_W-1:0]      root_q;
  logic                   merged;
  logic [SET_COUNT_W-1:0] set_count;

  modport source (output valid, root_p, root_q, merged, set_count, input ready);
  modport sink   (input valid, root_p, root_q, merged, set_count, output ready);
endinterface

// ----- rtl/core/ufwpc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufwpc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ufwpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ufwpc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufwpc_dpath: disjoint-set datapath
// Parent and size RAMs, walk pointer, root registers, set counter,
// clear sweep and the result register.
// ----------------------------------------------------------------------------
module ufwpc_dpath
  import ufwpc_pkg::*;
#(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ufwpc_cmd_t             cmd_i,
  output ufwpc_status_t          status_o,
  input  logic                   req_type_i,
  input  logic [ELEM_W-1:0]      elem_p_i,
  input  logic [ELEM_W-1:0]      elem_q_i,
  output logic [ELEM_W-1:0]      root_p_o,
  output logic [ELEM_W-1:0]      root_q_o,
  output logic                   merged_o,
  output logic [SET_COUNT_W-1:0] set_count_o
);

  // Elements above the field range are never addressed
  localparam int DEPTH = (NUM_ELEMENTS < MAX_DEPTH) ? NUM_ELEMENTS : MAX_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(NUM_ELEMENTS + 1);

  logic                   req_type_q;
  logic [ELEM_W-1:0]      elem_p_q, elem_q_q;
  logic [AW-1:0]          cur_q, cur_d;
  logic [ELEM_W-1:0]      root_p_q, root_p_d, root_q_q, root_q_d;
  logic [SIZE_W-1:0]      size_p_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [AW-1:0]          clr_idx_q, clr_idx_d;
  logic [ELEM_W-1:0]      root_p_out_q, root_q_out_q;
  logic                   merged_out_q;
  logic [SET_COUNT_W-1:0] set_count_out_q;

  logic [ELEM_W-1:0] elem_sel, root_sel;
  logic              p_in_range, q_in_range, can_merge;

  logic              par_we;
  logic [AW-1:0]     par_waddr, par_wdata, par_raddr, par_rdata;
  logic              size_we;
  logic [AW-1:0]     size_waddr, size_raddr;
  logic [SIZE_W-1:0] size_wdata, size_rdata, size_sum;
  logic              p_smaller;

  // Operand selection and range checks
  assign elem_sel   = cmd_i.sel ? elem_q_q : elem_p_q;
  assign root_sel   = cmd_i.sel ? root_q_q : root_p_q;
  assign p_in_range = 32'(elem_p_q) < 32'(NUM_ELEMENTS);
  assign q_in_range = 32'(elem_q_q) < 32'(NUM_ELEMENTS);
  assign can_merge  = p_in_range && q_in_range && (root_p_q != root_q_q);

  // Union: size_p_q holds size[root_p], RAM output holds size[root_q]
  assign p_smaller = size_p_q < size_rdata;
  assign size_sum  = size_p_q + size_rdata;

  // Parent RAM ports
  always_comb begin
    par_raddr = cur_q;
    if (cmd_i.walk_start) begin
      par_raddr = elem_sel[AW-1:0];
    end else if (cmd_i.walk_next || cmd_i.comp_write) begin
      par_raddr = par_rdata;
    end

    par_we    = 1'b0;
    par_waddr = clr_idx_q;
    par_wdata = clr_idx_q;
    if (cmd_i.clr) begin
      par_we = 1'b1;
    end else if (cmd_i.comp_write) begin
      par_we    = 1'b1;
      par_waddr = cur_q;
      par_wdata = root_sel[AW-1:0];
    end else if (cmd_i.link) begin
      par_we    = 1'b1;
      par_waddr = p_smaller ? root_p_q[AW-1:0] : root_q_q[AW-1:0];
      par_wdata = p_smaller ? root_q_q[AW-1:0] : root_p_q[AW-1:0];
    end
  end

  // Size RAM ports
  always_comb begin
    size_raddr = cmd_i.size_rd_b ? root_q_q[AW-1:0] : root_p_q[AW-1:0];
    size_we    = 1'b0;
    size_waddr = clr_idx_q;
    size_wdata = SIZE_W'(1);
    if (cmd_i.clr) begin
      size_we = 1'b1;
    end else if (cmd_i.link) begin
      size_we    = 1'b1;
      size_waddr = p_smaller ? root_q_q[AW-1:0] : root_p_q[AW-1:0];
      size_wdata = size_sum;
    end
  end

  ufwpc_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  ufwpc_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (DEPTH)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .raddr_i (size_raddr),
    .rdata_o (size_rdata)
  );

  // Walk pointer and roots
  always_comb begin
    cur_d    = cur_q;
    root_p_d = root_p_q;
    root_q_d = root_q_q;
    if (cmd_i.walk_start || cmd_i.root_from_cur) begin
      cur_d = elem_sel[AW-1:0];
    end else if (cmd_i.walk_next || cmd_i.comp_write) begin
      cur_d = par_rdata;
    end
    if (cmd_i.ld_req) begin
      root_p_d = '0;
      root_q_d = '0;
    end else if (cmd_i.root_from_elem || cmd_i.root_from_cur) begin
      if (cmd_i.sel) begin
        root_q_d = cmd_i.root_from_elem ? elem_sel : ELEM_W'(cur_q);
      end else begin
        root_p_d = cmd_i.root_from_elem ? elem_sel : ELEM_W'(cur_q);
      end
    end
  end

  // Set counter and clear index
  always_comb begin
    count_d   = count_q;
    clr_idx_d = clr_idx_q;
    if (cmd_i.link && (count_q != '0)) begin
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.clr) begin
      clr_idx_d = clr_idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CNT_W'(NUM_ELEMENTS);
      clr_idx_q <= '0;
    end else begin
      count_q   <= count_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    root_p_q <= root_p_d;
    root_q_q <= root_q_d;
    if (cmd_i.ld_req) begin
      req_type_q <= req_type_i;
      elem_p_q   <= elem_p_i;
      elem_q_q   <= elem_q_i;
    end
    if (cmd_i.size_rd_b) begin
      size_p_q <= size_rdata;
    end
    if (cmd_i.ld_out) begin
      root_p_out_q    <= root_p_q;
      root_q_out_q    <= root_q_q;
      merged_out_q    <= (req_type_q == REQ_UNION) && can_merge;
      set_count_out_q <= SET_COUNT_W'(count_q);
    end
  end

  // Status
  assign status_o.clr_last      = clr_idx_q == AW'(DEPTH - 1);
  assign status_o.elem_in_range = cmd_i.sel ? q_in_range : p_in_range;
  assign status_o.rd_is_self    = par_rdata == cur_q;
  assign status_o.cur_at_root   = ELEM_W'(cur_q) == root_sel;
  assign status_o.rd_at_root    = ELEM_W'(par_rdata) == root_sel;
  assign status_o.is_union      = req_type_q == REQ_UNION;
  assign status_o.can_merge     = can_merge;

  assign root_p_o    = root_p_out_q;
  assign root_q_o    = root_q_out_q;
  assign merged_o    = merged_out_q;
  assign set_count_o = set_count_out_q;

  // Set count only ever goes down
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q <= $past(count_q))
    else $error("set count increased");

  // A merge always joins two different roots
  a_link_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link |-> root_p_q != root_q_q)
    else $error("link of a root with itself");

  // Compression never rewrites the root's own entry
  a_comp_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.comp_write |-> ELEM_W'(cur_q) != root_sel)
    else $error("compression wrote the root entry");

endmodule

// ----- rtl/core/ufwpc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufwpc_ctrl: disjoint-set controller
// Sequences the clear sweep, the root walks, path compression, the size
// compare and link, and owns both handshake flags.
// ----------------------------------------------------------------------------
module ufwpc_ctrl
  import ufwpc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ufwpc_cmd_t    cmd_o,
  input  ufwpc_status_t status_i
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_START = 11'b000_0000_0100,
    S_FCHK  = 11'b000_0000_1000,
    S_CCHK  = 11'b000_0001_0000,
    S_CWR   = 11'b000_0010_0000,
    S_SZP   = 11'b000_0100_0000,
    S_SZQ   = 11'b000_1000_0000,
    S_LINK  = 11'b001_0000_0000,
    S_DONE  = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  logic   out_valid_q, out_valid_d;
  logic   to_q_walk;
  state_e after_walk;

  // Where to go when one element's walk and compression are finished
  assign to_q_walk  = !sel_q && status_i.is_union;
  assign after_walk = to_q_walk ? S_START :
                      (status_i.is_union && status_i.can_merge) ? S_SZP : S_DONE;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          sel_d        = 1'b0;
          state_d      = S_START;
        end
      end
      S_START: begin
        if (status_i.elem_in_range) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_FCHK;
        end else begin
          cmd_o.root_from_elem = 1'b1;
          state_d              = after_walk;
          sel_d                = sel_q | to_q_walk;
        end
      end
      S_FCHK: begin
        if (status_i.rd_is_self) begin
          cmd_o.root_from_cur = 1'b1;
          state_d             = S_CCHK;
        end else begin
          cmd_o.walk_next = 1'b1;
        end
      end
      S_CCHK: begin
        if (status_i.cur_at_root) begin
          state_d = after_walk;
          sel_d   = sel_q | to_q_walk;
        end else begin
          cmd_o.comp_read = 1'b1;
          state_d         = S_CWR;
        end
      end
      S_CWR: begin
        cmd_o.comp_write = 1'b1;
        if (status_i.rd_at_root) begin
          state_d = after_walk;
          sel_d   = sel_q | to_q_walk;
        end
      end
      S_SZP: begin
        cmd_o.size_rd_a = 1'b1;
        state_d         = S_SZQ;
      end
      S_SZQ: begin
        cmd_o.size_rd_b = 1'b1;
        state_d         = S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result flag: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  // Every accepted request starts with the walk of elem_p
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_START) && !sel_q)
    else $error("request not started on elem_p");

  // Link only follows both size reads
  a_link_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> $past(state_q) == S_SZQ)
    else $error("link without size reads");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !$past(cmd_o.ld_out))
    else $error("result register overwritten");

endmodule

// ----- rtl/core/union_find_weighted_path_compress.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_weighted_path_compress: disjoint-set engine
// Weighted quick-union with path compression over NUM_ELEMENTS elements.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over min(NUM_ELEMENTS, 1024)
// entries that writes every parent entry to itself and every size to one;
// req ready stays low until it ends. Requests are handled one at a time by
// a controller walking the parent RAM through its single read port, one
// parent link per cycle. A find passes through start, root search, a check,
// path compression and the result load; a union runs two such walks with
// compression back to back and, when it merges, reads both sizes and links
// the roots. With weighted union and compression chains stay short. A
// finished result waits in an output register, so the next request is
// accepted while the previous one is still waiting to be taken.
// ----------------------------------------------------------------------------
module union_find_weighted_path_compress
  import ufwpc_pkg::*;
#(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ufwpc_req_if.sink   req_i,
  ufwpc_rsp_if.source rsp_o
);

  ufwpc_cmd_t    cmd;
  ufwpc_status_t status;

  ufwpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ufwpc_dpath #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_type_i  (req_i.req_type),
    .elem_p_i    (req_i.elem_p),
    .elem_q_i    (req_i.elem_q),
    .root_p_o    (rsp_o.root_p),
    .root_q_o    (rsp_o.root_q),
    .merged_o    (rsp_o.merged),
    .set_count_o (rsp_o.set_count)
  );

endmodule

// ----- verif/ufwpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufwpc_checker: result checker for the disjoint-set engine
// Watches the request and result channels. Each accepted request is run
// through a private copy of the parent and size tables to work out the
// result due, and each accepted result is compared field by field with the
// oldest result due.
// ----------------------------------------------------------------------------
module ufwpc_checker
  import ufwpc_pkg::*;
#(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ufwpc_req_if  req_mon,
  ufwpc_rsp_if  rsp_mon,
  output int    fail_count_o,
  output int    pending_o,
  output int    merges_o,
  output int    sets_left_o
);

  localparam int TABLE_DEPTH = (NUM_ELEMENTS < MAX_DEPTH) ? NUM_ELEMENTS : MAX_DEPTH;

  typedef struct packed {
    logic [ELEM_W-1:0]      root_p;
    logic [ELEM_W-1:0]      root_q;
    logic                   merged;
    logic [SET_COUNT_W-1:0] set_count;
  } set_result_t;

  // Shadow forest
  logic [ELEM_W-1:0] parent_of [TABLE_DEPTH];
  logic [SIZE_W-1:0] tree_size [TABLE_DEPTH];
  int                sets_left;
  int                merges;
  int                fails;
  set_result_t       due_results [$];

  function automatic bit is_member(input int e);
    return e < NUM_ELEMENTS;
  endfunction

  // Root search, then point every node on the path straight at the root
  function automatic logic [ELEM_W-1:0] find_and_compress(input logic [ELEM_W-1:0] e);
    int r;
    int cur;
    int nx;
    int steps;
    r = e;
    steps = 0;
    while (parent_of[r] != r && steps < NUM_ELEMENTS) begin
      nx = parent_of[r];
      if (!is_member(nx)) break;
      r = nx;
      steps++;
    end
    cur = e;
    steps = 0;
    while (cur != r && steps < NUM_ELEMENTS) begin
      nx = parent_of[cur];
      parent_of[cur] = ELEM_W'(r);
      if (!is_member(nx)) break;
      cur = nx;
      steps++;
    end
    return ELEM_W'(r);
  endfunction

  // Update the shadow forest for one request and return its result
  function automatic set_result_t apply_request(input logic kind,
                                                input logic [ELEM_W-1:0] p,
                                                input logic [ELEM_W-1:0] q);
    set_result_t       res;
    logic [ELEM_W-1:0] rp;
    logic [ELEM_W-1:0] rq;
    rq = '0;
    res.merged = 1'b0;
    rp = is_member(p) ? find_and_compress(p) : p;
    if (kind == REQ_UNION) begin
      rq = is_member(q) ? find_and_compress(q) : q;
      if (is_member(p) && is_member(q) && rp != rq) begin
        // smaller tree goes under the larger root; on a tie root_p stays
        if (tree_size[rp] < tree_size[rq]) begin
          parent_of[rp] = rq;
          tree_size[rq] = tree_size[rq] + tree_size[rp];
        end else begin
          parent_of[rq] = rp;
          tree_size[rp] = tree_size[rp] + tree_size[rq];
        end
        if (sets_left > 0) sets_left--;
        res.merged = 1'b1;
        merges++;
      end
    end
    res.root_p    = rp;
    res.root_q    = rq;
    res.set_count = SET_COUNT_W'(sets_left);
    return res;
  endfunction

  // Compare results first: a result never leaves in the cycle its request enters
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    set_result_t got;
    set_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        parent_of[i] = ELEM_W'(i);
        tree_size[i] = SIZE_W'(1);
      end
      sets_left = NUM_ELEMENTS;
      merges    = 0;
      fails     = 0;
      due_results.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.root_p    = rsp_mon.root_p;
        got.root_q    = rsp_mon.root_q;
        got.merged    = rsp_mon.merged;
        got.set_count = rsp_mon.set_count;
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: root_p=%0d root_q=%0d merged=%0d count=%0d",
                 got.root_p, got.root_q, got.merged, got.set_count);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (got.root_p !== want.root_p) begin
            $error("root_p mismatch: expected %0d, actual %0d", want.root_p, got.root_p);
            fails++;
          end
          if (got.root_q !== want.root_q) begin
            $error("root_q mismatch: expected %0d, actual %0d", want.root_q, got.root_q);
            fails++;
          end
          if (got.merged !== want.merged) begin
            $error("merged mismatch: expected %0d, actual %0d", want.merged, got.merged);
            fails++;
          end
          if (got.set_count !== want.set_count) begin
            $error("set_count mismatch: expected %0d, actual %0d",
                   want.set_count, got.set_count);
            fails++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        due_results.push_back(apply_request(req_mon.req_type, req_mon.elem_p, req_mon.elem_q));
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_results.size();
    merges_o     <= merges;
    sets_left_o  <= sets_left;
  end

endmodule

// ----- verif/union_find_weighted_path_compress_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_weighted_path_compress_test: testbench top
// Drives find and union requests into the disjoint-set engine with random
// gaps on both channels: a directed opener, a random mix with clustered
// unions, and a chaining sweep that merges every element into one set.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module union_find_weighted_path_compress_test;
  import ufwpc_pkg::*;

  localparam int NUM_ELEMENTS  = 1024;
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 700;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 400;

  logic clk_i;
  logic rst_ni;

  ufwpc_req_if req_ch ();
  ufwpc_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int merge_count;
  int sets_left;
  int find_count  = 0;
  int union_count = 0;
  int sent        = 0;
  int idle_cycles = 0;
  bit send_burst  = 1'b0;

  union_find_weighted_path_compress #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  ufwpc_checker #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .merges_o    (merge_count),
    .sets_left_o (sets_left)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one request after a random gap and hold it until taken
  task automatic issue(input req_type_e kind, input logic [ELEM_W-1:0] p,
                       input logic [ELEM_W-1:0] q);
    int gap;
    if (sent % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.elem_p   <= p;
    req_ch.elem_q   <= q;
    do @(posedge clk_i); while (!req_ch.ready);
    if (kind == REQ_UNION) union_count++;
    else find_count++;
    sent++;
  endtask

  // Sender pause until every result due has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Random mix; the window clusters unions so trees grow and same-set cases occur
  task automatic random_request(input int window_base);
    int                pick;
    logic [ELEM_W-1:0] p;
    logic [ELEM_W-1:0] q;
    pick = $urandom_range(0, 99);
    p    = ELEM_W'($urandom);
    q    = ELEM_W'($urandom);
    if (pick < 35) begin
      issue(REQ_FIND, p, q);
    end else if (pick < 45) begin
      issue(REQ_FIND, ELEM_W'(window_base + $urandom_range(0, 31)), q);
    end else if (pick < 80) begin
      issue(REQ_UNION, p, q);
    end else begin
      issue(REQ_UNION, ELEM_W'(window_base + $urandom_range(0, 31)),
            ELEM_W'(window_base + $urandom_range(0, 31)));
    end
  endtask

  // Result side: random stalls, one long hold-off while the sender keeps going
  initial begin : result_side
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    forever begin
      if (taken % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      taken++;
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL union_find_weighted_path_compress");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict
  initial begin : request_side
    int window;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_FIND;
    req_ch.elem_p   <= '0;
    req_ch.elem_q   <= '0;
    rst_ni          <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, ties, same set, self union, a deep chain
    issue(REQ_FIND,  10'd0,    10'd1023);
    issue(REQ_FIND,  10'd1023, 10'd0);
    issue(REQ_UNION, 10'd0,    10'd1023);
    issue(REQ_UNION, 10'd1023, 10'd0);
    issue(REQ_UNION, 10'd5,    10'd5);
    issue(REQ_UNION, 10'd1,    10'd2);
    issue(REQ_UNION, 10'd3,    10'd1);
    issue(REQ_UNION, 10'h2AA,  10'h155);
    issue(REQ_UNION, 10'd0,    10'd3);
    issue(REQ_FIND,  10'd2,    10'h3FF);
    issue(REQ_UNION, 10'd700,  10'd701);
    issue(REQ_UNION, 10'd702,  10'd703);
    issue(REQ_UNION, 10'd700,  10'd702);
    issue(REQ_UNION, 10'd704,  10'd705);
    issue(REQ_UNION, 10'd706,  10'd707);
    issue(REQ_UNION, 10'd704,  10'd706);
    issue(REQ_UNION, 10'd700,  10'd704);
    issue(REQ_FIND,  10'd707,  10'd0);
    issue(REQ_FIND,  10'd707,  10'd0);
    issue(REQ_UNION, 10'd1023, 10'd707);
    issue(REQ_UNION, 10'd703,  10'd2);
    issue(REQ_FIND,  10'd1023, 10'd0);
    drain_results();

    // Random mix with a pause half way
    window = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) window = $urandom_range(0, 1023);
      random_request(window);
      if (i == RANDOM_ITEMS / 2) drain_results();
    end

    // Chain every neighbor pair so the count runs down to one set
    for (int k = 0; k < NUM_ELEMENTS - 1; k++) begin
      if ($urandom_range(0, 1) != 0) issue(REQ_UNION, ELEM_W'(k), ELEM_W'(k + 1));
      else issue(REQ_UNION, ELEM_W'(k + 1), ELEM_W'(k));
      if (k % 4 == 3) issue(REQ_FIND, ELEM_W'($urandom), ELEM_W'($urandom));
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d finds and %0d unions, %0d of which merged two sets;",
             find_count, union_count, merge_count);
    $display("the set count ended at %0d.", sets_left);
    if (fail_count == 0) begin
      $display("PASS union_find_weighted_path_compress");
    end else begin
      $display("FAIL union_find_weighted_path_compress");
    end
    $finish;
  end

endmodule
